// File: sv/ipv4_decimal_trie_counters_assert.svh
// assertion macros used by the trie walker
`ifndef IPV4_DECIMAL_TRIE_COUNTERS_ASSERT_SVH
`define IPV4_DECIMAL_TRIE_COUNTERS_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define DTC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define DTC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define DTC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define DTC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// File: sv/dtc_pkg.sv
// shared constants, types and digit split for the decimal trie counters
package dtc_pkg;

   // key and trie shape
   localparam int KEY_DIGITS      = 12;
   localparam int FANOUT          = 10;
   localparam int COUNTER_NUM     = 4;
   localparam int OCTET_NUM       = 4;
   localparam int OCTET_W         = 10;
   localparam int DIGIT_W         = 4;
   localparam int LEVEL_W         = 4;
   localparam int DATA_W          = 32;
   localparam int STATUS_W        = 2;

   // defaults for the top level parameters
   localparam int NODE_COUNT_DEF  = 4096;
   localparam int COUNT_WIDTH_DEF = 32;

   // stream packing
   localparam int REQ_TDATA_W     = 168;
   localparam int RSP_TDATA_W     = 160;
   localparam int ADD_BASE        = OCTET_NUM * OCTET_W;

   localparam logic [LEVEL_W-1:0] LEVEL_LAST = LEVEL_W'(KEY_DIGITS - 1);
   localparam logic [LEVEL_W-1:0] LEVEL_LEAF = LEVEL_W'(KEY_DIGITS);

   // request kinds
   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_LOOKUP = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

   typedef logic [DIGIT_W-1:0] digit_type;

   typedef struct packed {
      logic                                 op;
      digit_type [KEY_DIGITS-1:0]           digits;
      logic [COUNTER_NUM-1:0][DATA_W-1:0]   adds;
   } dtc_request_type;

   typedef struct packed {
      logic [STATUS_W-1:0]                  status;
      logic [COUNTER_NUM-1:0][DATA_W-1:0]   counts;
      logic [DATA_W-1:0]                    total;
   } dtc_result_type;

   // saturate at 999 and split into hundreds, tens, units (index 0 is hundreds)
   function automatic digit_type [2:0] dtc_octet_digits(input logic [OCTET_W-1:0] octet);
      logic [OCTET_W-1:0] v;
      logic [15:0]        hp;
      digit_type          h;
      logic [6:0]         r;
      logic [13:0]        tp;
      digit_type          t;
      digit_type          u;
      digit_type [2:0]    d;
      v  = (octet > 10'd999) ? 10'd999 : octet;
      // v / 100 by reciprocal, exact below 1000
      hp = 16'(v) * 16'd41;
      h  = hp[15:12];
      r  = 7'(v - 10'(h) * 10'd100);
      // r / 10 by reciprocal, exact below 100
      tp = 14'(r) * 14'd103;
      t  = tp[13:10];
      u  = 4'(r - 7'(t) * 7'd10);
      d[0] = h;
      d[1] = t;
      d[2] = u;
      return d;
   endfunction

endpackage

// File: sv/dtc_link_ram.sv
// node pool memory: one row of child links per trie node
module dtc_link_ram
   import dtc_pkg::*;
#(
   parameter int NODE_COUNT = NODE_COUNT_DEF,
   localparam int NW = $clog2(NODE_COUNT)
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [NW-1:0]              wr_addr,
   input  logic [FANOUT-1:0][NW-1:0]  wr_data,
   input  logic                       rd_en,
   input  logic [NW-1:0]              rd_addr,
   output logic [FANOUT-1:0][NW-1:0]  rd_data
);

   logic [FANOUT-1:0][NW-1:0] mem [NODE_COUNT];
   logic [FANOUT-1:0][NW-1:0] rd_data_ff;

   // one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/dtc_count_ram.sv
// leaf counter memory: four counters per node
module dtc_count_ram
   import dtc_pkg::*;
#(
   parameter int NODE_COUNT  = NODE_COUNT_DEF,
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
   localparam int NW = $clog2(NODE_COUNT)
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [NW-1:0]                            wr_addr,
   input  logic [COUNTER_NUM-1:0][COUNT_WIDTH-1:0]  wr_data,
   input  logic                                     rd_en,
   input  logic [NW-1:0]                            rd_addr,
   output logic [COUNTER_NUM-1:0][COUNT_WIDTH-1:0]  rd_data
);

   logic [COUNTER_NUM-1:0][COUNT_WIDTH-1:0] mem [NODE_COUNT];
   logic [COUNTER_NUM-1:0][COUNT_WIDTH-1:0] rd_data_ff;

   // one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/dtc_walker.sv
// trie walk, node allocation and counter update sequencer
`include "ipv4_decimal_trie_counters_assert.svh"
module dtc_walker
   import dtc_pkg::*;
#(
   parameter int NODE_COUNT  = NODE_COUNT_DEF,
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
   localparam int NW = $clog2(NODE_COUNT)
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // request side
   input  logic                                     start_valid,
   output logic                                     start_ready,
   input  dtc_request_type                          start_req,
   // result side
   output logic                                     done_valid,
   input  logic                                     done_take,
   output dtc_result_type                           result,
   // link memory
   output logic                                     link_rd_en,
   output logic [NW-1:0]                            link_rd_addr,
   input  logic [FANOUT-1:0][NW-1:0]                link_rd_data,
   output logic                                     link_wr_en,
   output logic [NW-1:0]                            link_wr_addr,
   output logic [FANOUT-1:0][NW-1:0]                link_wr_data,
   // counter memory
   output logic                                     cnt_rd_en,
   output logic [NW-1:0]                            cnt_rd_addr,
   input  logic [COUNTER_NUM-1:0][COUNT_WIDTH-1:0]  cnt_rd_data,
   output logic                                     cnt_wr_en,
   output logic [NW-1:0]                            cnt_wr_addr,
   output logic [COUNTER_NUM-1:0][COUNT_WIDTH-1:0]  cnt_wr_data
);

   localparam logic [NW+1:0] NODE_LIMIT = (NW+2)'(NODE_COUNT);

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_WALK  = 3'd1;
   localparam logic [2:0] S_BUILD = 3'd2;
   localparam logic [2:0] S_COUNT = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0]                               state_ff, state_in;
   logic                                     op_ff, op_in;
   digit_type [KEY_DIGITS-1:0]               dig_ff, dig_in;
   logic [COUNTER_NUM-1:0][DATA_W-1:0]       add_ff, add_in;
   logic [LEVEL_W-1:0]                       lvl_ff, lvl_in;
   logic [NW-1:0]                            node_ff, node_in;
   logic [FANOUT-1:0][NW-1:0]                row_ff, row_in;
   logic                                     leaf_new_ff, leaf_new_in;
   logic [NW:0]                              next_free_ff, next_free_in;
   logic [DATA_W-1:0]                        total_ff, total_in;
   logic                                     root_valid_ff, root_valid_in;
   dtc_result_type                           res_ff, res_in;

   logic [FANOUT-1:0][NW-1:0]                rd_row;
   digit_type                                cur_dig;
   logic [NW-1:0]                            link;
   logic [NW-1:0]                            alloc_idx;
   logic [LEVEL_W-1:0]                       need;
   logic [NW+1:0]                            room_sum;
   logic                                     has_room;
   logic [FANOUT-1:0][NW-1:0]                build_row;
   logic [COUNTER_NUM-1:0][COUNT_WIDTH-1:0]  sums;
   logic [COUNTER_NUM-1:0][DATA_W-1:0]       sums32;
   logic [COUNTER_NUM-1:0][DATA_W-1:0]       rd32;
   logic [DATA_W-1:0]                        total_inc;

   // root row reads as all null until its first write
   assign rd_row    = (node_ff == '0 && !root_valid_ff) ? '0 : link_rd_data;
   assign cur_dig   = dig_ff[lvl_ff];
   assign link      = rd_row[cur_dig];
   assign alloc_idx = next_free_ff[NW-1:0];
   assign total_inc = total_ff + 1'b1;

   // pool space check for the missing levels
   assign need      = LEVEL_LEAF - lvl_ff;
   assign room_sum  = (NW+2)'(next_free_ff) + (NW+2)'(need);
   assign has_room  = (room_sum <= NODE_LIMIT);

   // row to write while building: parent link set, leaf row stays null
   always_comb begin
      build_row = row_ff;
      if (lvl_ff != LEVEL_LEAF) begin
         build_row[cur_dig] = alloc_idx;
      end
   end

   // counter update, a fresh leaf starts from zero
   always_comb begin
      for (int k = 0; k < COUNTER_NUM; k++) begin
         sums[k]   = (leaf_new_ff ? '0 : cnt_rd_data[k]) + COUNT_WIDTH'(add_ff[k]);
         sums32[k] = DATA_W'(sums[k]);
         rd32[k]   = DATA_W'(cnt_rd_data[k]);
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      dig_in        = dig_ff;
      add_in        = add_ff;
      lvl_in        = lvl_ff;
      node_in       = node_ff;
      row_in        = row_ff;
      leaf_new_in   = leaf_new_ff;
      next_free_in  = next_free_ff;
      total_in      = total_ff;
      root_valid_in = root_valid_ff;
      res_in        = res_ff;

      start_ready   = (state_ff == S_IDLE);
      done_valid    = 1'b0;
      link_rd_en    = 1'b0;
      link_rd_addr  = link;
      link_wr_en    = 1'b0;
      link_wr_addr  = node_ff;
      link_wr_data  = build_row;
      cnt_rd_en     = 1'b0;
      cnt_rd_addr   = link;
      cnt_wr_en     = 1'b0;
      cnt_wr_addr   = node_ff;
      cnt_wr_data   = sums;

      unique case (state_ff)
         S_IDLE: begin
            if (start_valid) begin
               op_in        = start_req.op;
               dig_in       = start_req.digits;
               add_in       = start_req.adds;
               lvl_in       = '0;
               node_in      = '0;
               link_rd_en   = 1'b1;
               link_rd_addr = '0;
               state_in     = S_WALK;
            end
         end
         S_WALK: begin
            if (link != '0) begin
               node_in = link;
               lvl_in  = lvl_ff + 1'b1;
               if (lvl_ff == LEVEL_LAST) begin
                  // leaf exists: fetch its counters
                  cnt_rd_en   = 1'b1;
                  leaf_new_in = 1'b0;
                  state_in    = S_COUNT;
               end else begin
                  link_rd_en = 1'b1;
               end
            end else if (op_ff == REQ_LOOKUP) begin
               res_in.status = ST_NOT_FOUND;
               res_in.counts = '0;
               res_in.total  = total_ff;
               state_in      = S_DONE;
            end else if (!has_room) begin
               res_in.status = ST_FULL;
               res_in.counts = '0;
               res_in.total  = total_ff;
               state_in      = S_DONE;
            end else begin
               row_in   = rd_row;
               state_in = S_BUILD;
            end
         end
         S_BUILD: begin
            // one row write per new level, then the leaf row
            link_wr_en = 1'b1;
            row_in     = '0;
            if (node_ff == '0) begin
               root_valid_in = 1'b1;
            end
            if (lvl_ff == LEVEL_LEAF) begin
               leaf_new_in = 1'b1;
               state_in    = S_COUNT;
            end else begin
               node_in      = alloc_idx;
               next_free_in = next_free_ff + 1'b1;
               lvl_in       = lvl_ff + 1'b1;
            end
         end
         S_COUNT: begin
            if (op_ff == REQ_LOOKUP) begin
               res_in.status = ST_OK;
               res_in.counts = rd32;
               res_in.total  = total_ff;
            end else begin
               cnt_wr_en     = 1'b1;
               total_in      = total_inc;
               res_in.status = ST_OK;
               res_in.counts = sums32;
               res_in.total  = total_inc;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            done_valid = 1'b1;
            if (done_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign result = res_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         next_free_ff  <= (NW+1)'(1);
         total_ff      <= '0;
         root_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         next_free_ff  <= next_free_in;
         total_ff      <= total_in;
         root_valid_ff <= root_valid_in;
      end
   end

   // item payload
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      dig_ff      <= dig_in;
      add_ff      <= add_in;
      lvl_ff      <= lvl_in;
      node_ff     <= node_in;
      row_ff      <= row_in;
      leaf_new_ff <= leaf_new_in;
      res_ff      <= res_in;
   end

   `DTC_ASSERT_IMPLY(a_pool_bound, clock, reset, 1'b1, next_free_ff <= (NW+1)'(NODE_COUNT), "allocator ran past the pool")
   `DTC_ASSERT_IMPLY(a_write_alloc, clock, reset, link_wr_en, (NW+1)'(link_wr_addr) < next_free_ff, "link row written for an unallocated node")
   `DTC_ASSERT_IMPLY(a_walk_level, clock, reset, state_ff == S_WALK, lvl_ff < LEVEL_LEAF, "walk level out of range")
   `DTC_ASSERT_NEXT(a_build_alloc, clock, reset, state_ff == S_BUILD && lvl_ff != LEVEL_LEAF, next_free_ff == $past(next_free_ff) + 1'b1, "build step did not allocate one node")

endmodule

// File: sv/ipv4_decimal_trie_counters.sv
// top level: stream ports, digit split, result register, trie memories
//
//   channel  | ports                      | moves
//   ---------+----------------------------+-----------------------------------
//   request  | req_tvalid/tready/tdata/tuser | one insert or lookup item
//   result   | rsp_tvalid/tready/tdata/tuser | one status and counters item
//
// one item is walked at a time, with one link memory access per trie level: a
// read per existing level, and for an insert that adds nodes a write for the
// parent row and one per new node, the leaf included; a lookup miss or a full
// reject stops at the first missing level. no clearing pass: the root row
// is masked until first written and every other row is written when its node is
// allocated, so items are taken right after reset; req_tready is low in reset.
// a full result register holds the sequencer in its last step.
module ipv4_decimal_trie_counters
   import dtc_pkg::*;
#(
   parameter int NODE_COUNT  = NODE_COUNT_DEF,
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // octet_a, octet_b, octet_c, octet_d, add_one, add_two, add_three, add_four
   input  logic [REQ_TDATA_W-1:0]  req_tdata,
   // req_type
   input  logic [0:0]              req_tuser,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // count_one, count_two, count_three, count_four, insert_count
   output logic [RSP_TDATA_W-1:0]  rsp_tdata,
   // status
   output logic [STATUS_W-1:0]     rsp_tuser
);

   localparam int NW = $clog2(NODE_COUNT);

   dtc_request_type                          req;
   dtc_result_type                           result;
   logic                                     walk_ready;
   logic                                     done_valid;
   logic                                     done_take;
   logic                                     rsp_valid_ff;
   dtc_result_type                           rsp_ff;

   logic                                     link_rd_en;
   logic [NW-1:0]                            link_rd_addr;
   logic [FANOUT-1:0][NW-1:0]                link_rd_data;
   logic                                     link_wr_en;
   logic [NW-1:0]                            link_wr_addr;
   logic [FANOUT-1:0][NW-1:0]                link_wr_data;
   logic                                     cnt_rd_en;
   logic [NW-1:0]                            cnt_rd_addr;
   logic [COUNTER_NUM-1:0][COUNT_WIDTH-1:0]  cnt_rd_data;
   logic                                     cnt_wr_en;
   logic [NW-1:0]                            cnt_wr_addr;
   logic [COUNTER_NUM-1:0][COUNT_WIDTH-1:0]  cnt_wr_data;

   // unpack the request and split each octet into decimal digits
   always_comb begin
      req.op = req_tuser[0];
      for (int i = 0; i < OCTET_NUM; i++) begin
         {req.digits[3*i+2], req.digits[3*i+1], req.digits[3*i]} =
            dtc_octet_digits(req_tdata[i*OCTET_W +: OCTET_W]);
      end
      for (int k = 0; k < COUNTER_NUM; k++) begin
         req.adds[k] = req_tdata[ADD_BASE + k*DATA_W +: DATA_W];
      end
   end

   // no item is taken while reset is high
   assign req_tready = walk_ready && !reset;

   dtc_walker #(
      .NODE_COUNT  (NODE_COUNT),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_walker (
      .clock        (clock),
      .reset        (reset),
      .start_valid  (req_tvalid),
      .start_ready  (walk_ready),
      .start_req    (req),
      .done_valid   (done_valid),
      .done_take    (done_take),
      .result       (result),
      .link_rd_en   (link_rd_en),
      .link_rd_addr (link_rd_addr),
      .link_rd_data (link_rd_data),
      .link_wr_en   (link_wr_en),
      .link_wr_addr (link_wr_addr),
      .link_wr_data (link_wr_data),
      .cnt_rd_en    (cnt_rd_en),
      .cnt_rd_addr  (cnt_rd_addr),
      .cnt_rd_data  (cnt_rd_data),
      .cnt_wr_en    (cnt_wr_en),
      .cnt_wr_addr  (cnt_wr_addr),
      .cnt_wr_data  (cnt_wr_data)
   );

   dtc_link_ram #(
      .NODE_COUNT (NODE_COUNT)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_wr_en),
      .wr_addr (link_wr_addr),
      .wr_data (link_wr_data),
      .rd_en   (link_rd_en),
      .rd_addr (link_rd_addr),
      .rd_data (link_rd_data)
   );

   dtc_count_ram #(
      .NODE_COUNT  (NODE_COUNT),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_wr_en),
      .wr_addr (cnt_wr_addr),
      .wr_data (cnt_wr_data),
      .rd_en   (cnt_rd_en),
      .rd_addr (cnt_rd_addr),
      .rd_data (cnt_rd_data)
   );

   // result register, loads when empty or being drained
   assign done_take = done_valid && (!rsp_valid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done_take) begin
         rsp_ff <= result;
      end
   end

   // pack the result item
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tdata  = {rsp_ff.total, rsp_ff.counts[3], rsp_ff.counts[2],
                        rsp_ff.counts[1], rsp_ff.counts[0]};

endmodule
